### hdl/sst_pkg.sv
// Shared types and constants for the session timeout table.
`default_nettype none

package sst_pkg;

	localparam int unsigned TIME_W      = 48;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned SID_W       = 5;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned CNT_W       = 6;

	localparam logic [VAL_W-1:0] VALIDITY_RESET = 32'd30000000;

	typedef logic [TIME_W-1:0] usec_t;

	typedef enum logic [KIND_W-1:0] {
		RES_ARM_ACK = 2'd0,
		RES_EXPIRED = 2'd1,
		RES_NONE    = 2'd2
	} res_kind_t;

	typedef enum logic {
		REQ_ARM     = 1'b0,
		REQ_PROCESS = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARM_SCAN,
		ST_ARM_ACK,
		ST_PROC_SCAN,
		ST_PROC_END,
		ST_PROC_FINAL
	} sst_state_t;

endpackage

`default_nettype wire

### hdl/session_timeout_table_top.sv
// Session timeout table: per-session unique deadlines with expiry reporting.
//
// Channels: req (req_valid/req_stall) carries one request per beat; rsp
// (rsp_valid/rsp_stall) returns result beats; cfg (cfg_valid/cfg_ready)
// writes the validity period, always ready; the user writes it only while
// the block is idle, which the block itself does not enforce.
// Requests are taken one at a time: req_stall is high while a request works.
// Arm: disarms the session, forms now + validity (saturated), then walks the
//   deadline memory round-robin; every hit on an armed entry bumps the
//   candidate by 1 us. Done after SESSIONS compares in a row with no hit.
//   One ack beat. Out-of-range session ids are dropped with no beat.
// Process: each pass reads all SESSIONS entries once and picks the earliest
//   expired armed deadline; one pass per expired session plus a closing pass
//   (none once 32 are found), at most 32 reported per request. The final beat
//   has last_result set; if none expired, one "nothing expired" beat is sent.
// Timing is set by the single read port of the deadline memory: one entry
// per cycle. Results sit in an output register; a stalled beat holds and the
// sequencer waits, so a new request may be accepted while a beat is pending.
// Reset clears all armed flags and loads the validity period of 30 s; the
// deadline memory is not cleared, only armed entries are ever used.
`default_nettype none

module session_timeout_table_top #(
	parameter int unsigned SESSIONS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sst_pkg::VAL_W-1:0]    cfg_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         req_type,
	input  logic [sst_pkg::SID_W-1:0]    session_id,
	input  logic [sst_pkg::TIME_W-1:0]   now_time,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [sst_pkg::KIND_W-1:0]   result_kind,
	output logic [sst_pkg::SID_W-1:0]    result_session,
	output logic [sst_pkg::TIME_W-1:0]   result_deadline,
	output logic                         last_result
);
	import sst_pkg::*;

	localparam int unsigned IW = $clog2(SESSIONS);
	localparam int unsigned CW = $clog2(SESSIONS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SESSIONS - 1);
	localparam logic [CW-1:0] CLEAN_DONE = CW'(SESSIONS);

	// deadline memory, one synchronous read port
	usec_t dl_mem [SESSIONS];

	sst_state_t state_q, state_d;

	logic [VAL_W-1:0]    validity_q;
	logic [SESSIONS-1:0] armed_q;

	logic [IW-1:0]  sid_q;
	usec_t          now_q;
	usec_t          dl_q;
	logic [IW-1:0]  rd_idx_q;
	logic           issue_done_q;
	logic [CW-1:0]  clean_q;
	logic           cmp_v_s1;
	logic [IW-1:0]  cmp_idx_s1;
	usec_t          rd_data_s1;

	logic           best_found_q;
	logic [IW-1:0]  best_idx_q;
	usec_t          best_dl_q;
	logic           pend_v_q;
	logic [IW-1:0]  pend_idx_q;
	usec_t          pend_dl_q;
	logic [CNT_W-1:0] n_q;

	logic             rsp_valid_q;
	res_kind_t        rsp_kind_q;
	logic [SID_W-1:0] rsp_sid_q;
	usec_t            rsp_dl_q;
	logic             rsp_last_q;

	// sequencer strobes
	logic      rd_en;
	logic      arm_start;
	logic      proc_start;
	logic      pass_start;
	logic      take_best;
	logic      arm_commit;
	logic      emit;
	res_kind_t emit_kind;
	logic [IW-1:0] emit_idx;
	usec_t     emit_dl;
	logic      emit_last;

	logic          slot_free;
	logic          sid_ok;
	logic [TIME_W:0] dl_sum;
	usec_t         dl_init;
	logic          arm_cmp;
	logic          hit;
	logic          better;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign sid_ok    = (32'(session_id) < SESSIONS);

	assign dl_sum  = {1'b0, now_time} + (TIME_W + 1)'(validity_q);
	assign dl_init = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	// compare stage
	assign arm_cmp = (state_q == ST_ARM_SCAN) && (clean_q != CLEAN_DONE) && cmp_v_s1;
	assign hit     = armed_q[cmp_idx_s1] && (rd_data_s1 == dl_q);
	assign better  = cmp_v_s1 && (state_q == ST_PROC_SCAN) && armed_q[cmp_idx_s1]
		&& (rd_data_s1 <= now_q) && (!best_found_q || (rd_data_s1 < best_dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		arm_start  = 1'b0;
		proc_start = 1'b0;
		pass_start = 1'b0;
		take_best  = 1'b0;
		arm_commit = 1'b0;
		emit       = 1'b0;
		emit_kind  = RES_NONE;
		emit_idx   = '0;
		emit_dl    = '0;
		emit_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_PROCESS) begin
						proc_start = 1'b1;
						pass_start = 1'b1;
						state_d    = ST_PROC_SCAN;
					end else if (sid_ok) begin
						arm_start  = 1'b1;
						pass_start = 1'b1;
						state_d    = ST_ARM_SCAN;
					end
				end
			end
			ST_ARM_SCAN: begin
				if (clean_q == CLEAN_DONE) begin
					state_d = ST_ARM_ACK;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_ARM_ACK: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_kind  = RES_ARM_ACK;
					emit_idx   = sid_q;
					emit_dl    = dl_q;
					emit_last  = 1'b1;
					arm_commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_PROC_SCAN: begin
				rd_en = !issue_done_q;
				if (cmp_v_s1 && (cmp_idx_s1 == LAST_IDX)) begin
					state_d = ST_PROC_END;
				end
			end
			ST_PROC_END: begin
				if (best_found_q) begin
					// previous find is not the last one: flush it, keep the new one
					if (!pend_v_q || slot_free) begin
						emit      = pend_v_q;
						emit_kind = RES_EXPIRED;
						emit_idx  = pend_idx_q;
						emit_dl   = pend_dl_q;
						take_best = 1'b1;
						if (n_q == CNT_W'(MAX_RESULTS - 1)) begin
							state_d = ST_PROC_FINAL;
						end else begin
							pass_start = 1'b1;
							state_d    = ST_PROC_SCAN;
						end
					end
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					if (pend_v_q) begin
						emit_kind = RES_EXPIRED;
						emit_idx  = pend_idx_q;
						emit_dl   = pend_dl_q;
					end
					state_d = ST_IDLE;
				end
			end
			ST_PROC_FINAL: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = RES_EXPIRED;
					emit_idx  = pend_idx_q;
					emit_dl   = pend_dl_q;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory: write on arm commit, read one entry per cycle while scanning
	always_ff @(posedge clk) begin
		if (arm_commit) begin
			dl_mem[sid_q] <= dl_q;
		end
		if (rd_en) begin
			rd_data_s1 <= dl_mem[rd_idx_q];
		end
		cmp_idx_s1 <= rd_idx_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			validity_q   <= VALIDITY_RESET;
			armed_q      <= '0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			clean_q      <= '0;
			cmp_v_s1     <= 1'b0;
			best_found_q <= 1'b0;
			pend_v_q     <= 1'b0;
			n_q          <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				validity_q <= cfg_data;
			end

			if (arm_start) begin
				armed_q[IW'(session_id)] <= 1'b0;
			end else if (arm_commit) begin
				armed_q[sid_q] <= 1'b1;
			end else if (take_best) begin
				armed_q[best_idx_q] <= 1'b0;
			end

			cmp_v_s1 <= rd_en;

			if (pass_start) begin
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
				clean_q      <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
					if (rd_idx_q == LAST_IDX) begin
						issue_done_q <= 1'b1;
					end
				end
				if (arm_cmp) begin
					clean_q <= hit ? '0 : clean_q + 1'b1;
				end
				if (better) begin
					best_found_q <= 1'b1;
				end
			end

			if (proc_start) begin
				pend_v_q <= 1'b0;
				n_q      <= '0;
			end else if (take_best) begin
				pend_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (arm_start) begin
			sid_q <= IW'(session_id);
			dl_q  <= dl_init;
		end else if (arm_cmp && hit) begin
			dl_q <= dl_q + 1'b1;
		end
		if (proc_start) begin
			now_q <= now_time;
		end
		if (better) begin
			best_idx_q <= cmp_idx_s1;
			best_dl_q  <= rd_data_s1;
		end
		if (take_best) begin
			pend_idx_q <= best_idx_q;
			pend_dl_q  <= best_dl_q;
		end
		if (emit) begin
			rsp_kind_q <= emit_kind;
			rsp_sid_q  <= SID_W'(emit_idx);
			rsp_dl_q   <= emit_dl;
			rsp_last_q <= emit_last;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign result_kind     = rsp_kind_q;
	assign result_session  = rsp_sid_q;
	assign result_deadline = rsp_dl_q;
	assign last_result     = rsp_last_q;

endmodule

`default_nettype wire

### hdl/sst_checker.sv
// Port-level checker for the session timeout table, bound to the top level.
`default_nettype none

module sst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [sst_pkg::KIND_W-1:0]   result_kind,
	input logic [sst_pkg::SID_W-1:0]    result_session,
	input logic [sst_pkg::TIME_W-1:0]   result_deadline,
	input logic                         last_result
);
	import sst_pkg::*;

	// a stalled beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_kind)
			&& $stable(result_session) && $stable(result_deadline) && $stable(last_result))
		else $error("rsp beat changed under stall");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (result_kind == RES_ARM_ACK) || (result_kind == RES_EXPIRED)
			|| (result_kind == RES_NONE))
		else $error("illegal result kind");

	// ack and empty report are always the only beat of their request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((result_kind == RES_ARM_ACK) || (result_kind == RES_NONE))
			|-> last_result)
		else $error("single-beat result without last");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (result_kind == RES_NONE)
			|-> (result_session == '0) && (result_deadline == '0))
		else $error("empty report carries data");

endmodule

bind session_timeout_table_top sst_checker u_sst_checker (.*);

`default_nettype wire

### tb/tb_session_timeout_table_top.sv
// Self-checking testbench for the session timeout table: directed and random requests.
`default_nettype none

module tb_session_timeout_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int unsigned SESSIONS    = 32;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam usec_t       TIME_MAX    = '1;

	// one result beat as the block should present it
	typedef struct packed {
		res_kind_t          kind;
		logic [SID_W-1:0]   sess;
		usec_t              deadline;
		logic               last;
	} table_result_t;

	// Shadow of the deadline table: per-session deadline and armed flag, the
	// validity period, and the beats still owed by the block, oldest first.
	class session_deadline_book;
		usec_t            deadline_mem [SESSIONS];
		bit               armed [SESSIONS];
		logic [VAL_W-1:0] validity;
		table_result_t    owed_results [$];
		int unsigned      mismatches;

		function new();
			foreach (armed[i]) begin
				armed[i] = 1'b0;
				deadline_mem[i] = '0;
			end
			validity = VALIDITY_RESET;
			mismatches = 0;
		endfunction

		function void load_validity(logic [VAL_W-1:0] value);
			validity = value;
		endfunction

		function int unsigned outstanding();
			return owed_results.size();
		endfunction

		// Work out the beats caused by one accepted request.
		function void note_request(req_kind_t kind, logic [SID_W-1:0] sid, usec_t now);
			logic [TIME_W:0]  sum;
			usec_t            dl;
			bit               hit;
			bit               found;
			int               best;
			int               n;
			logic [SID_W-1:0] best_sid;
			table_result_t    beat;
			if (kind == REQ_ARM) begin
				armed[sid] = 1'b0;
				sum = {1'b0, now} + (TIME_W + 1)'(validity);
				dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
				// bump past deadlines held by other armed sessions; wraps at max
				do begin
					hit = 1'b0;
					foreach (armed[i])
						if (armed[i] && deadline_mem[i] == dl)
							hit = 1'b1;
					if (hit)
						dl = dl + 1'b1;
				end while (hit);
				deadline_mem[sid] = dl;
				armed[sid] = 1'b1;
				beat = '{RES_ARM_ACK, sid, dl, 1'b1};
				owed_results.push_back(beat);
			end else begin
				n = 0;
				while (n < MAX_RESULTS) begin
					found = 1'b0;
					best = 0;
					for (int i = 0; i < SESSIONS; i++)
						if (armed[i] && deadline_mem[i] <= now &&
								(!found || deadline_mem[i] < deadline_mem[best])) begin
							best = i;
							found = 1'b1;
						end
					if (!found)
						break;
					armed[best] = 1'b0;
					best_sid = best[SID_W-1:0];
					beat = '{RES_EXPIRED, best_sid, deadline_mem[best], 1'b0};
					owed_results.push_back(beat);
					n++;
				end
				if (n == 0) begin
					beat = '{RES_NONE, '0, '0, 1'b1};
					owed_results.push_back(beat);
				end else begin
					beat = owed_results.pop_back();
					beat.last = 1'b1;
					owed_results.push_back(beat);
				end
			end
		endfunction

		function void check_result(logic [KIND_W-1:0] kind, logic [SID_W-1:0] sess,
				usec_t deadline, logic last);
			table_result_t want;
			if (owed_results.size() == 0) begin
				$display("%0t: stray beat, expected none, actual kind %0d session %0d deadline %0d",
					$time, kind, sess, deadline);
				mismatches++;
				return;
			end
			want = owed_results.pop_front();
			if (kind !== want.kind) begin
				$display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
				mismatches++;
			end
			if (sess !== want.sess) begin
				$display("%0t: result_session expected %0d actual %0d", $time, want.sess, sess);
				mismatches++;
			end
			if (deadline !== want.deadline) begin
				$display("%0t: result_deadline expected %0d actual %0d", $time,
					want.deadline, deadline);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: last_result expected %0d actual %0d", $time, want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [VAL_W-1:0]   cfg_data = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               req_type = 1'b0;
	logic [SID_W-1:0]   session_id = '0;
	logic [TIME_W-1:0]  now_time = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [KIND_W-1:0]  result_kind;
	logic [SID_W-1:0]   result_session;
	logic [TIME_W-1:0]  result_deadline;
	logic               last_result;

	// no random idling on either side while set
	bit                 steady_run = 1'b0;
	int unsigned        cycle_count = 0;

	session_deadline_book book = new();

	session_timeout_table_top #(
		.SESSIONS(SESSIONS)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.session_id      (session_id),
		.now_time        (now_time),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.result_kind     (result_kind),
		.result_session  (result_session),
		.result_deadline (result_deadline),
		.last_result     (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, about 18% of cycles
	always @(posedge clk) begin
		rsp_stall <= !steady_run && ($urandom_range(0, 99) < 18);
	end

	// every result beat taken at this edge is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			book.check_result(result_kind, result_session, result_deadline, last_result);
	end

	// hard stop well above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic usec_t any_time();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[TIME_W-1:0];
	endfunction

	// One request beat, with an optional random gap in front; valid stays up
	// when the next beat follows right away.
	task automatic issue_request(input req_kind_t kind, input logic [SID_W-1:0] sid,
			input usec_t now);
		while (!steady_run && $urandom_range(0, 99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= kind;
		session_id <= sid;
		now_time   <= now;
		do @(posedge clk); while (req_stall);
		book.note_request(kind, sid, now);
	endtask

	// The period may only change with the block idle: nothing owed, no request
	// in flight. Sampled on the falling edge so the check side has settled.
	task automatic write_validity(input logic [VAL_W-1:0] value);
		req_valid <= 1'b0;
		do @(negedge clk); while (book.outstanding() != 0 || req_stall);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.load_validity(value);
	endtask

	initial begin
		logic [VAL_W-1:0] period;
		usec_t            clock_now;
		usec_t            probe;
		int unsigned      pick;
		logic [SID_W-1:0] sid;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset period of 30 s ---
		issue_request(REQ_ARM, 5'd0, 48'd0);
		issue_request(REQ_ARM, 5'd1, 48'd0);          // collides, moves on by 1 us
		issue_request(REQ_ARM, 5'd31, 48'd0);
		issue_request(REQ_PROCESS, 5'd0, 48'd0);      // nothing expired yet
		issue_request(REQ_PROCESS, 5'd7, 48'd30000000); // exactly at the deadline
		issue_request(REQ_ARM, 5'd0, 48'd2);          // lands on a held deadline
		issue_request(REQ_PROCESS, 5'd31, TIME_MAX);  // rest expire, ascending

		// --- directed: largest period, saturation and wrap at the top ---
		write_validity(32'hFFFF_FFFF);
		issue_request(REQ_ARM, 5'd2, TIME_MAX);       // saturates
		issue_request(REQ_ARM, 5'd3, TIME_MAX);       // max taken, wraps to 0
		issue_request(REQ_ARM, 5'd4, TIME_MAX - 48'd5); // max and 0 taken
		issue_request(REQ_ARM, 5'd2, 48'd0);          // re-arm frees the max slot
		issue_request(REQ_ARM, 5'd5, 48'hFFFF_0000_0001); // overflow by exactly one
		issue_request(REQ_PROCESS, 5'd0, 48'h1234);
		issue_request(REQ_PROCESS, 5'd0, TIME_MAX);

		// --- directed: zero period ---
		write_validity(32'd0);
		issue_request(REQ_ARM, 5'd10, 48'd100);
		issue_request(REQ_ARM, 5'd10, 48'd100);       // re-arm keeps its own deadline
		issue_request(REQ_ARM, 5'd11, 48'd100);
		issue_request(REQ_PROCESS, 5'd0, 48'd99);
		issue_request(REQ_PROCESS, 5'd0, 48'd101);

		// --- random phases, each with its own period and time base ---
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 5)
				0: period = 32'd0;
				1: period = $urandom_range(1, 40);
				2: period = $urandom;
				3: period = 32'hFFFF_FFFF;
				default: period = $urandom_range(0, 1000);
			endcase
			write_validity(period);
			steady_run <= (phase == 3 || phase == 4);

			case ($urandom_range(0, 2))
				0: clock_now = TIME_W'($urandom_range(0, 1000));
				1: clock_now = any_time();
				default: clock_now = TIME_MAX - TIME_W'($urandom_range(0, 200));
			endcase

			// fill every session at one instant, then expire all 32 in one request
			if (phase == 1 || phase == 6) begin
				for (int k = 0; k < SESSIONS; k++)
					issue_request(REQ_ARM, k[SID_W-1:0], clock_now);
				issue_request(REQ_PROCESS, SID_W'($urandom_range(0, 31)), TIME_MAX);
			end

			// mostly a forward-moving clock so arms collide and expire in order
			for (int k = 0; k < 22; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					sid = $urandom_range(0, 1) ? SID_W'($urandom_range(0, 7))
						: SID_W'($urandom_range(0, 31));
					issue_request(REQ_ARM, sid, clock_now);
					clock_now = clock_now + TIME_W'($urandom_range(0, 2));
				end else if (pick < 80) begin
					probe = clock_now + TIME_W'(period) - TIME_W'($urandom_range(0, 16));
					issue_request(REQ_PROCESS, SID_W'($urandom_range(0, 31)), probe);
				end else if (pick < 88) begin
					issue_request(REQ_PROCESS, SID_W'($urandom_range(0, 31)), clock_now);
				end else if (pick < 93) begin
					issue_request(REQ_PROCESS, SID_W'($urandom_range(0, 31)), TIME_MAX);
				end else begin
					issue_request(req_kind_t'($urandom_range(0, 1)),
						SID_W'($urandom_range(0, 31)), any_time());
				end
			end
		end

		steady_run <= 1'b0;
		req_valid <= 1'b0;
		do @(negedge clk); while (book.outstanding() != 0);
		// allow a late stray beat to show up
		repeat (2 * SESSIONS + 8) @(posedge clk);

		if (book.mismatches == 0 && book.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
